// File: hdl/vfc_pkg.sv
// Shared types and constants of the triangle vertex FIFO cache.
`timescale 1ns / 1ps
package vfc_pkg;

	// Width of a vertex buffer slot index on the result side.
	localparam int SLOT_W = 16;

	// A triangle has three corners, handled one per step.
	localparam int CORNERS  = 3;
	localparam int CORNER_W = 2;

	typedef logic [CORNER_W-1:0] corner_t;

	localparam corner_t CORNER_FIRST  = 2'd0;
	localparam corner_t CORNER_SECOND = 2'd1;
	localparam corner_t CORNER_LAST   = 2'd2;

	typedef logic [SLOT_W-1:0] slot_t;

	typedef enum logic {
		ST_IDLE,
		ST_CORNER
	} vfc_state_t;

endpackage

// File: hdl/vfc_lane.sv
// One cache entry: stored vertex id and slot, valid bit and id compare.
`timescale 1ns / 1ps
module vfc_lane #(
	parameter int ID_BITS = 32
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 clear,
	input  logic                 wr_en,
	input  logic [ID_BITS-1:0]   look_id,
	input  vfc_pkg::slot_t       wr_slot,
	output logic                 hit,
	output vfc_pkg::slot_t       hit_slot
);
	import vfc_pkg::*;

	logic               valid_q;
	logic [ID_BITS-1:0] id_q;
	slot_t              slot_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (clear) begin
			valid_q <= 1'b0;
		end else if (wr_en) begin
			valid_q <= 1'b1;
		end
	end

	// A miss always stores the id that was just looked up.
	always_ff @(posedge clk) begin
		if (wr_en) begin
			id_q   <= look_id;
			slot_q <= wr_slot;
		end
	end

	assign hit      = valid_q && (id_q == look_id);
	assign hit_slot = hit ? slot_q : '0;

endmodule

// File: hdl/vfc_merge.sv
// Combines the lane compare results into one hit flag and one slot.
`timescale 1ns / 1ps
module vfc_merge #(
	parameter int LANES = 12
) (
	input  logic [LANES-1:0]      lane_hit,
	input  vfc_pkg::slot_t        lane_slot [LANES],
	output logic                  any_hit,
	output vfc_pkg::slot_t        hit_slot
);
	import vfc_pkg::*;

	// Valid entries never hold the same id twice, so at most one lane hits
	// and a plain OR of the masked slots selects it.
	always_comb begin
		hit_slot = '0;
		for (int i = 0; i < LANES; i++) begin
			hit_slot = hit_slot | lane_slot[i];
		end
	end

	assign any_hit = |lane_hit;

endmodule

// File: hdl/triangle_vertex_fifo_cache.sv
// Top level of the triangle vertex FIFO cache: sequencer, fill counter and result register.
`timescale 1ns / 1ps
//
// Channel   Direction  Transfer contents
// s_*       in         s_tdata: three vertex ids; s_tuser: visible, clear cache, clear buffer
// m_*       out        m_tdata: three buffer slots; m_tuser: three miss flags, overflow
//
// A visible triangle holds the input for the cycle of its transfer and three
// corner steps, each a parallel compare across all cache lanes followed by the
// merge and, on a miss, one push into the ring. Its result is registered by the
// last corner step, and the next triangle can transfer in the cycle after the
// last corner step. An invisible triangle needs no corner steps.
// The corner chain is what sets the pace, since each corner sees entries pushed
// by the corner before it.
// Reset empties the ring and zeroes the fill counter and overflow flag; it is
// asynchronous and active low. The result waits in its own register, so the
// next triangle runs its first corners while a result is stalled; only the
// last corner step waits for that register to free up.
module triangle_vertex_fifo_cache #(
	parameter int CACHE_ENTRIES  = 12,
	parameter int BUFFER_SLOTS   = 65535,
	parameter int VERTEX_ID_BITS = 32,
	localparam int S_DATA_W = ((3 * VERTEX_ID_BITS + 7) / 8) * 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	// s_tdata, low bit up: vertex_first, vertex_second, vertex_third, zero fill
	input  logic [S_DATA_W-1:0]  s_tdata,
	// s_tuser, low bit up: triangle_visible, clear_cache, clear_buffer
	input  logic [2:0]           s_tuser,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	// m_tdata, low bit up: slot_first, slot_second, slot_third
	output logic [47:0]          m_tdata,
	// m_tuser, low bit up: miss_first, miss_second, miss_third, buffer_overflow
	output logic [3:0]           m_tuser,
	output logic                 m_tvalid,
	input  logic                 m_tready
);
	import vfc_pkg::*;

	localparam int POS_W  = (CACHE_ENTRIES > 1) ? $clog2(CACHE_ENTRIES) : 1;
	localparam int FILL_W = $clog2(BUFFER_SLOTS + 1);
	localparam logic [POS_W-1:0]  POS_LAST  = POS_W'(CACHE_ENTRIES - 1);
	localparam logic [FILL_W-1:0] FILL_FULL = FILL_W'(BUFFER_SLOTS);
	localparam logic [FILL_W-1:0] FILL_SAT  = FILL_W'(BUFFER_SLOTS - 1);

	typedef logic [VERTEX_ID_BITS-1:0] vid_t;

	// Sequencer state.
	vfc_state_t state_q, state_d;
	corner_t    corner_q;

	// Latched corner ids of the triangle in flight.
	vid_t ids_q [CORNERS];

	// Ring and buffer bookkeeping.
	logic [POS_W-1:0]  newest_q;
	logic [FILL_W-1:0] fill_q;
	logic              overflow_q;

	// Results of the first two corners, held until the last corner finishes.
	slot_t work_slot_q [2];
	logic  work_miss_q [2];

	// Result register.
	logic  out_valid_q;
	slot_t out_slot_q [CORNERS];
	logic  out_miss_q [CORNERS];
	logic  out_ovf_q;

	// Handshake and step controls.
	logic in_xfer;
	logic out_xfer;
	logic stall;
	logic step;
	logic last_step;

	// Lookup datapath.
	vid_t              look_id;
	logic [CACHE_ENTRIES-1:0] lane_hit;
	slot_t             lane_slot [CACHE_ENTRIES];
	logic              any_hit;
	slot_t             hit_slot;
	logic              push;
	logic [POS_W-1:0]  newest_next;
	logic              buf_full;
	slot_t             push_slot;
	slot_t             corner_slot;
	logic              ovf_next;
	logic              clear_lanes;

	assign in_xfer  = s_tvalid && s_tready;
	assign out_xfer = m_tvalid && m_tready;

	// The last corner needs the result register free, or freeing this cycle.
	assign stall     = (corner_q == CORNER_LAST) && out_valid_q && !m_tready;
	assign step      = (state_q == ST_CORNER) && !stall;
	assign last_step = step && (corner_q == CORNER_LAST);

	// Next state.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (in_xfer && s_tuser[0]) begin
					state_d = ST_CORNER;
				end
			end
			ST_CORNER: begin
				if (last_step) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// Sequencer outputs.
	always_comb begin
		s_tready = 1'b0;
		case (state_q)
			ST_IDLE:   s_tready = 1'b1;
			ST_CORNER: s_tready = 1'b0;
			default:   s_tready = 1'b0;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Id of the corner under lookup.
	always_comb begin
		case (corner_q)
			CORNER_FIRST:  look_id = ids_q[0];
			CORNER_SECOND: look_id = ids_q[1];
			CORNER_LAST:   look_id = ids_q[2];
			default:       look_id = ids_q[0];
		endcase
	end

	// One lane per ring entry; all entries are compared in the same cycle.
	assign clear_lanes = in_xfer && s_tuser[1];
	assign newest_next = (newest_q == POS_LAST) ? '0 : newest_q + 1'b1;
	assign push        = step && !any_hit;

	for (genvar i = 0; i < CACHE_ENTRIES; i++) begin : g_lane
		vfc_lane #(
			.ID_BITS (VERTEX_ID_BITS)
		) u_lane (
			.clk      (clk),
			.arst_n   (arst_n),
			.clear    (clear_lanes),
			.wr_en    (push && (newest_next == POS_W'(i))),
			.look_id  (look_id),
			.wr_slot  (push_slot),
			.hit      (lane_hit[i]),
			.hit_slot (lane_slot[i])
		);
	end

	vfc_merge #(
		.LANES (CACHE_ENTRIES)
	) u_merge (
		.lane_hit  (lane_hit),
		.lane_slot (lane_slot),
		.any_hit   (any_hit),
		.hit_slot  (hit_slot)
	);

	// A push into a full buffer reuses the last slot and raises overflow.
	assign buf_full    = (fill_q == FILL_FULL);
	assign push_slot   = buf_full ? SLOT_W'(FILL_SAT) : SLOT_W'(fill_q);
	assign corner_slot = any_hit ? hit_slot : push_slot;
	assign ovf_next    = overflow_q || (push && buf_full);

	// Ring position, fill counter and overflow flag. Clears only come with an
	// input transfer, which never coincides with a corner step.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			newest_q   <= POS_LAST;
			fill_q     <= '0;
			overflow_q <= 1'b0;
		end else if (in_xfer) begin
			if (s_tuser[1]) begin
				newest_q <= POS_LAST;
			end
			if (s_tuser[2]) begin
				fill_q     <= '0;
				overflow_q <= 1'b0;
			end
		end else if (push) begin
			newest_q   <= newest_next;
			overflow_q <= ovf_next;
			if (!buf_full) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	// Corner counter.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			corner_q <= CORNER_FIRST;
		end else if (in_xfer) begin
			corner_q <= CORNER_FIRST;
		end else if (step && !last_step) begin
			corner_q <= corner_q + 1'b1;
		end
	end

	// Triangle ids and per-corner work results.
	always_ff @(posedge clk) begin
		if (in_xfer) begin
			ids_q[0] <= s_tdata[VERTEX_ID_BITS-1:0];
			ids_q[1] <= s_tdata[2*VERTEX_ID_BITS-1:VERTEX_ID_BITS];
			ids_q[2] <= s_tdata[3*VERTEX_ID_BITS-1:2*VERTEX_ID_BITS];
		end
		if (step && (corner_q == CORNER_FIRST)) begin
			work_slot_q[0] <= corner_slot;
			work_miss_q[0] <= !any_hit;
		end
		if (step && (corner_q == CORNER_SECOND)) begin
			work_slot_q[1] <= corner_slot;
			work_miss_q[1] <= !any_hit;
		end
	end

	// Result register: loaded by the last corner step, emptied by a transfer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (last_step) begin
			out_valid_q <= 1'b1;
		end else if (out_xfer) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (last_step) begin
			out_slot_q[0] <= work_slot_q[0];
			out_slot_q[1] <= work_slot_q[1];
			out_slot_q[2] <= corner_slot;
			out_miss_q[0] <= work_miss_q[0];
			out_miss_q[1] <= work_miss_q[1];
			out_miss_q[2] <= !any_hit;
			out_ovf_q     <= ovf_next;
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_slot_q[2], out_slot_q[1], out_slot_q[0]};
	assign m_tuser  = {out_ovf_q, out_miss_q[2], out_miss_q[1], out_miss_q[0]};

endmodule

// File: tb/vfc_tb_pkg.sv
// Transfer layouts shared by the vertex cache testbench and its checker.
`timescale 1ns / 1ps
package vfc_tb_pkg;

	import vfc_pkg::*;

	// s_tuser, low bit up: visible, clear cache, clear buffer.
	typedef struct packed {
		logic clear_buffer;
		logic clear_cache;
		logic visible;
	} triangle_flags_t;

	// {m_tuser, m_tdata}, low bit up: three slots, three miss flags, overflow.
	typedef struct packed {
		logic               overflow;
		logic [CORNERS-1:0] miss;
		slot_t [CORNERS-1:0] slot;
	} corner_slots_t;

endpackage

// File: tb/vfc_checker.sv
// Checker of the vertex cache: predicts each triangle's slots and compares the results.
`timescale 1ns / 1ps
module vfc_checker #(
	parameter int CACHE_ENTRIES  = 12,
	parameter int BUFFER_SLOTS   = 65535,
	parameter int VERTEX_ID_BITS = 32,
	localparam int S_DATA_W = ((3 * VERTEX_ID_BITS + 7) / 8) * 8
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic [S_DATA_W-1:0] s_tdata,
	input  logic [2:0]          s_tuser,
	input  logic                s_tvalid,
	input  logic                s_tready,
	input  logic [47:0]         m_tdata,
	input  logic [3:0]          m_tuser,
	input  logic                m_tvalid,
	input  logic                m_tready,
	output int                  mismatches,
	output int                  pending,
	output int                  results_checked,
	output int                  corner_hits,
	output int                  overflow_results
);
	import vfc_pkg::*;
	import vfc_tb_pkg::*;

	localparam int REPORT_LIMIT = 10;

	// Own copy of the cache: ring of (id, slot), newest position and number of valid entries.
	logic [VERTEX_ID_BITS-1:0] ring_id [CACHE_ENTRIES];
	slot_t                     ring_slot [CACHE_ENTRIES];
	int                        newest_pos = CACHE_ENTRIES - 1;
	int                        ring_fill = 0;
	int unsigned               buffer_fill = 0;
	logic                      overflow_flag = 1'b0;

	corner_slots_t expected_slots_q [$];

	// Looks one corner up from the newest valid entry back; pushes it on a miss.
	task automatic place_vertex(input logic [VERTEX_ID_BITS-1:0] id, output slot_t slot,
			output logic missed);
		int   pos;
		int   n;
		logic found;
		pos = newest_pos;
		found = 1'b0;
		slot = '0;
		for (n = 0; n < ring_fill; n++) begin
			if (!found && ring_id[pos] == id) begin
				found = 1'b1;
				slot = ring_slot[pos];
			end
			pos = (pos == 0) ? CACHE_ENTRIES - 1 : pos - 1;
		end
		missed = !found;
		if (!found) begin
			if (buffer_fill >= BUFFER_SLOTS) begin
				// Full buffer: the slot saturates at the last index and overflow sticks.
				buffer_fill = BUFFER_SLOTS;
				slot = slot_t'(BUFFER_SLOTS - 1);
				overflow_flag = 1'b1;
			end else begin
				slot = slot_t'(buffer_fill);
				buffer_fill++;
			end
			if (ring_fill < CACHE_ENTRIES)
				ring_fill++;
			newest_pos = (newest_pos == CACHE_ENTRIES - 1) ? 0 : newest_pos + 1;
			ring_id[newest_pos] = id;
			ring_slot[newest_pos] = slot;
		end
	endtask

	task automatic predict_triangle(input logic [S_DATA_W-1:0] ids, input triangle_flags_t flags);
		corner_slots_t expected;
		slot_t         slot;
		logic          missed;
		int            c;
		// Clears act first, and they act on invisible triangles too.
		if (flags.clear_buffer) begin
			buffer_fill = 0;
			overflow_flag = 1'b0;
		end
		if (flags.clear_cache) begin
			newest_pos = CACHE_ENTRIES - 1;
			ring_fill = 0;
		end
		if (flags.visible) begin
			for (c = 0; c < CORNERS; c++) begin
				place_vertex(ids[c*VERTEX_ID_BITS +: VERTEX_ID_BITS], slot, missed);
				expected.slot[c] = slot;
				expected.miss[c] = missed;
			end
			expected.overflow = overflow_flag;
			expected_slots_q.push_back(expected);
		end
	endtask

	task automatic check_result(input corner_slots_t got);
		corner_slots_t expected;
		logic          wrong;
		int            c;
		if (expected_slots_q.size() == 0) begin
			mismatches++;
			if (mismatches <= REPORT_LIMIT)
				$display("Unexpected result at %0t: slots %0d %0d %0d miss %b overflow %b",
					$realtime, got.slot[0], got.slot[1], got.slot[2], got.miss, got.overflow);
		end else begin
			expected = expected_slots_q.pop_front();
			wrong = (got.overflow !== expected.overflow);
			for (c = 0; c < CORNERS; c++) begin
				if (got.slot[c] !== expected.slot[c] || got.miss[c] !== expected.miss[c])
					wrong = 1'b1;
				if (!expected.miss[c])
					corner_hits++;
			end
			if (expected.overflow)
				overflow_results++;
			if (wrong) begin
				mismatches++;
				if (mismatches <= REPORT_LIMIT) begin
					$display("Mismatch on result %0d at %0t, miss bits third..first:",
						results_checked, $realtime);
					$display("  expected slots %0d %0d %0d miss %b overflow %b",
						expected.slot[0], expected.slot[1], expected.slot[2],
						expected.miss, expected.overflow);
					$display("  got      slots %0d %0d %0d miss %b overflow %b",
						got.slot[0], got.slot[1], got.slot[2], got.miss, got.overflow);
				end
			end
			results_checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_slots_q.delete();
			newest_pos = CACHE_ENTRIES - 1;
			ring_fill = 0;
			buffer_fill = 0;
			overflow_flag = 1'b0;
			pending <= 0;
		end else begin
			if (m_tvalid && m_tready)
				check_result(corner_slots_t'({m_tuser, m_tdata}));
			if (s_tvalid && s_tready)
				predict_triangle(s_tdata, triangle_flags_t'(s_tuser));
			pending <= expected_slots_q.size();
		end
	end

endmodule

// File: tb/tb.sv
// Testbench top of the triangle vertex FIFO cache: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
//
// The top only drives the two stream channels and decides the verdict. The
// checker beside the block watches every transfer on both sides, runs its own
// copy of the vertex cache and compares each result with the oldest prediction.
//
// Stimulus runs in three parts:
//  - a short directed part: extreme ids, repeated corners inside one triangle,
//    ring eviction seen by later corners, clears on visible and invisible
//    triangles, and both clears together;
//  - a run of fresh ids: forty triangles in which every corner misses, so the
//    ring wraps many times and the fill counter climbs from a buffer clear,
//    followed by a hit on a recent entry and a buffer clear that keeps the
//    cached slots;
//  - a random part: ids from a small pool (so the 12-entry ring hits often),
//    strips that reuse two corners of the previous triangle, fully random ids
//    and the all-zeros and all-ones ids, with rare clears.
// Both sides idle at random. Once the result side holds off for a long
// stretch while triangles keep coming, so the block fills up and stalls its
// input; the sender also pauses until every expected result has arrived.
module tb;

	import vfc_pkg::*;
	import vfc_tb_pkg::*;

	localparam int ID_W         = 32;
	localparam int S_DATA_W     = ((3 * ID_W + 7) / 8) * 8;
	localparam int RESET_CYCLES = 8;
	localparam int FRESH_ROUNDS = 40;          // three fresh ids each
	localparam int RANDOM_ITEMS = 1100;
	localparam int POOL_SIZE    = 20;
	localparam int LONG_HOLD    = 300;
	localparam int END_SLACK    = 20;
	localparam int CYCLE_LIMIT  = 2_000_000;
	localparam logic [ID_W-1:0] FRESH_BASE = 32'hA000_0000;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic [S_DATA_W-1:0] s_tdata = '0;        // vertex_first, vertex_second, vertex_third
	logic [2:0]          s_tuser = '0;        // triangle_visible, clear_cache, clear_buffer
	logic                s_tvalid = 1'b0;
	logic                s_tready;
	logic [47:0]         m_tdata;             // slot_first, slot_second, slot_third
	logic [3:0]          m_tuser;             // miss_first, miss_second, miss_third, overflow
	logic                m_tvalid;
	logic                m_tready = 1'b0;

	int mismatches;
	int pending;
	int results_checked;
	int corner_hits;
	int overflow_results;

	// Set by the stimulus; hold_request is cleared by the result side after its long hold.
	logic quiet = 1'b0;
	logic hold_request = 1'b0;

	int triangles_sent = 0;
	int visible_sent = 0;
	int unsigned fresh_count = 0;
	logic [ID_W-1:0] vertex_pool [POOL_SIZE];

	always #10 clk = ~clk;

	triangle_vertex_fifo_cache i_dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready)
	);

	vfc_checker i_checker (
		.clk              (clk),
		.arst_n           (arst_n),
		.s_tdata          (s_tdata),
		.s_tuser          (s_tuser),
		.s_tvalid         (s_tvalid),
		.s_tready         (s_tready),
		.m_tdata          (m_tdata),
		.m_tuser          (m_tuser),
		.m_tvalid         (m_tvalid),
		.m_tready         (m_tready),
		.mismatches       (mismatches),
		.pending          (pending),
		.results_checked  (results_checked),
		.corner_hits      (corner_hits),
		.overflow_results (overflow_results)
	);

	// Most gaps are zero or short, a few are long; a quiet stretch has none.
	function automatic int pick_gap();
		int r;
		if (quiet)
			return 0;
		r = $urandom_range(0, 99);
		if (r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Ids that were never used before, far from the random pool values.
	function automatic logic [ID_W-1:0] fresh_vertex();
		fresh_count++;
		return FRESH_BASE + fresh_count;
	endfunction

	function automatic logic [ID_W-1:0] pick_vertex();
		int r;
		r = $urandom_range(0, 99);
		if (r < 60)
			return vertex_pool[$urandom_range(0, POOL_SIZE - 1)];
		if (r < 90)
			return $urandom();
		if (r < 95)
			return '0;
		return '1;
	endfunction

	// Offers one triangle, holds it until the transfer and then idles at random.
	// The valid stays high when no gap follows, so it is never lowered and
	// raised within one step.
	task automatic offer_triangle(input logic [ID_W-1:0] id_a, id_b, id_c,
			input logic visible, clear_cache, clear_buffer);
		triangle_flags_t flags;
		int              gap;
		flags.visible = visible;
		flags.clear_cache = clear_cache;
		flags.clear_buffer = clear_buffer;
		s_tdata <= {id_c, id_b, id_a};
		s_tuser <= flags;
		s_tvalid <= 1'b1;
		@(posedge clk);
		while (!s_tready)
			@(posedge clk);
		triangles_sent++;
		if (visible)
			visible_sent++;
		gap = pick_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	// Stops offering and waits until the checker has seen every predicted result.
	// The first edge lets the count of the last transfer settle.
	task automatic wait_for_results();
		s_tvalid <= 1'b0;
		@(posedge clk);
		while (pending != 0)
			@(posedge clk);
	endtask

	// Result side: random ready runs and stalls, or one long hold on request.
	initial begin : result_side
		int run;
		int stall;
		@(posedge clk);
		forever begin
			if (hold_request) begin
				m_tready <= 1'b0;
				repeat (LONG_HOLD) @(posedge clk);
				hold_request = 1'b0;
			end else begin
				m_tready <= 1'b1;
				run = quiet ? 16 : $urandom_range(1, 12);
				repeat (run) @(posedge clk);
				stall = pick_gap();
				if (stall > 0) begin
					m_tready <= 1'b0;
					repeat (stall) @(posedge clk);
				end
			end
		end
	end

	initial begin : watchdog
		int cycles;
		cycles = 0;
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("Run stopped by the cycle limit with %0d results still pending.", pending);
		$display("== FAIL ==");
		$finish;
	end

	initial begin : stimulus
		logic [ID_W-1:0] last_id;
		logic [ID_W-1:0] id_a;
		logic [ID_W-1:0] id_b;
		logic [ID_W-1:0] id_c;
		logic [ID_W-1:0] prev_b;
		logic [ID_W-1:0] prev_c;
		int              k;
		int              n;
		for (k = 0; k < POOL_SIZE; k++)
			vertex_pool[k] = $urandom();
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed part. Repeated corners within one triangle hit the entry the
		// earlier corner just pushed.
		offer_triangle('0, '0, '0, 1'b1, 1'b0, 1'b0);
		offer_triangle('1, '0, 32'h1234_5678, 1'b1, 1'b0, 1'b0);
		offer_triangle('1, 32'h1234_5678, '0, 1'b1, 1'b0, 1'b0);
		// An invisible triangle must not push its corners.
		offer_triangle(33, 34, 35, 1'b0, 1'b0, 1'b0);
		offer_triangle(33, 34, 35, 1'b1, 1'b0, 1'b0);
		// Nine more fresh ids wrap the ring and evict the three oldest entries.
		offer_triangle(100, 101, 102, 1'b1, 1'b0, 1'b0);
		offer_triangle(103, 104, 105, 1'b1, 1'b0, 1'b0);
		offer_triangle(106, 107, 108, 1'b1, 1'b0, 1'b0);
		// Id 0 was evicted; pushing it evicts 33, which the third corner then misses.
		offer_triangle('0, 108, 33, 1'b1, 1'b0, 1'b0);
		// Clears on invisible triangles, then on visible ones, then both together.
		offer_triangle(7, 8, 9, 1'b0, 1'b1, 1'b0);
		offer_triangle(34, 35, 34, 1'b1, 1'b0, 1'b0);
		offer_triangle(34, 200, 201, 1'b1, 1'b0, 1'b1);
		offer_triangle(7, 8, 9, 1'b0, 1'b0, 1'b1);
		offer_triangle(202, 203, 34, 1'b1, 1'b0, 1'b0);
		offer_triangle(34, 202, 5, 1'b1, 1'b1, 1'b1);
		offer_triangle(5, 6, 7, 1'b0, 1'b1, 1'b1);
		offer_triangle(32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA, 1'b1, 1'b0, 1'b0);
		offer_triangle(32'h5555_5555, '1, 32'h8000_0001, 1'b1, 1'b1, 1'b0);
		offer_triangle(32'h7FFF_FFFE, 32'h5555_5555, '1, 1'b1, 1'b0, 1'b0);

		// Fresh ids: pause until the directed results are in, then run back to
		// back so that every corner takes a new slot and the ring keeps wrapping.
		wait_for_results();
		quiet = 1'b1;
		for (k = 0; k < FRESH_ROUNDS; k++) begin
			id_a = fresh_vertex();
			id_b = fresh_vertex();
			id_c = fresh_vertex();
			offer_triangle(id_a, id_b, id_c, 1'b1, k == 0, k == 0);
		end
		last_id = id_c;
		// Two more pushes, with a hit on the entry pushed just before them.
		offer_triangle(fresh_vertex(), fresh_vertex(), last_id, 1'b1, 1'b0, 1'b0);
		// Buffer clear on an invisible triangle; cached slots stay.
		offer_triangle(last_id, last_id, last_id, 1'b0, 1'b0, 1'b1);
		offer_triangle(last_id, fresh_vertex(), fresh_vertex(), 1'b1, 1'b0, 1'b0);
		quiet = 1'b0;

		// Random part.
		prev_b = vertex_pool[0];
		prev_c = vertex_pool[1];
		for (n = 0; n < RANDOM_ITEMS; n++) begin
			if (n == 300) begin
				// Long hold on the result side while triangles keep coming.
				hold_request = 1'b1;
				quiet = 1'b1;
			end
			if (n == 340)
				quiet = 1'b0;
			if (n == 600)
				wait_for_results();
			if (n == 800)
				quiet = 1'b1;
			if (n == 880)
				quiet = 1'b0;
			if ($urandom_range(0, 99) < 35) begin
				// Strip: the new triangle shares an edge with the previous one.
				id_a = prev_b;
				id_b = prev_c;
				id_c = pick_vertex();
			end else begin
				id_a = pick_vertex();
				id_b = pick_vertex();
				id_c = pick_vertex();
			end
			if ($urandom_range(0, 9) == 0)
				vertex_pool[$urandom_range(0, POOL_SIZE - 1)] = $urandom();
			offer_triangle(id_a, id_b, id_c, $urandom_range(0, 99) < 85,
				$urandom_range(0, 99) < 4, $urandom_range(0, 99) < 3);
			prev_b = id_b;
			prev_c = id_c;
		end

		wait_for_results();
		repeat (END_SLACK) @(posedge clk);
		$display("Covered %0d triangles (%0d visible): directed cases, fresh-id runs, random ids.",
			triangles_sent, visible_sent);
		$display("Checked %0d results: %0d corner hits, %0d results with overflow set.",
			results_checked, corner_hits, overflow_results);
		if (mismatches == 0 && pending == 0) begin
			$display("== PASS ==");
		end else begin
			$display("%0d mismatches, %0d results never arrived.", mismatches, pending);
			$display("== FAIL ==");
		end
		$finish;
	end

endmodule
